/* design/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define WWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define WWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/wwc_pkg.sv */
// shared constants and types of the word wrap around circle unit
// no dependencies; imported by the interfaces, the units and the checker
package wwc_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // fixed field widths
   localparam int PEN_Y_BITS = 16;
   localparam int CFG8_BITS  = 8;

   // register reset values
   localparam int LINE_WIDTH_RST    = 800;
   localparam int LINE_HEIGHT_RST   = 20;
   localparam int WORD_GAP_RST      = 3;
   localparam int STEP_SIZE_RST     = 4;
   localparam int CIRCLE_X_RST      = 400;
   localparam int CIRCLE_Y_RST      = 400;
   localparam int CIRCLE_RADIUS_RST = 100;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LINE_WIDTH    = 3'd0,
      CSR_LINE_HEIGHT   = 3'd1,
      CSR_WORD_GAP      = 3'd2,
      CSR_STEP_SIZE     = 3'd3,
      CSR_CIRCLE_X      = 3'd4,
      CSR_CIRCLE_Y      = 3'd5,
      CSR_CIRCLE_RADIUS = 3'd6
   } csr_index_type;

   // status of the overlap unit back to the sequencer
   typedef struct packed {
      logic done;
      logic hit;
   } hit_status_type;

endpackage

/* design/wwc_if.sv */
// request and response channel interfaces with valid/ready handshake
// depends on wwc_pkg for the default coordinate width and the pen y width
interface wwc_req_if import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [CoordBits-1:0] word_width;
   logic                 first_word;

   modport source (output valid, output word_width, output first_word, input ready);
   modport sink   (input valid, input word_width, input first_word, output ready);
endinterface

interface wwc_rsp_if import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [CoordBits-1:0]  place_x;
   logic [PEN_Y_BITS-1:0] place_y;

   modport source (output valid, output place_x, output place_y, input ready);
   modport sink   (input valid, input place_x, input place_y, output ready);
endinterface

/* design/word_wrap_around_circle_unit.sv */
// One item at a time; next transfer taken after the result. When the first overlap test clears,
// it goes straight to the result. A test is longer when the squared distance is needed (one multiplier).
// A hit adds, per line: a divide unless the word runs past the line end, a test at the line end
// if the quotient is nonzero and up to log2(line_width) search tests.
// Reset: synchronous, active high; pen to origin, registers to defaults, no clearing pass.
// Top level: configuration registers and the sequencer, overlap and divider units.
module word_wrap_around_circle_unit import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   wwc_req_if.sink                   req_ch,
   wwc_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CoordBits-1:0]      csr_wdata
);

   logic [CoordBits-1:0]  line_width_ff;
   logic [CFG8_BITS-1:0]  line_height_ff;
   logic [CFG8_BITS-1:0]  word_gap_ff;
   logic [CFG8_BITS-1:0]  step_size_ff;
   logic [CoordBits-1:0]  circle_x_ff;
   logic [CoordBits-1:0]  circle_y_ff;
   logic [CoordBits-2:0]  circle_radius_ff;

   logic [CFG8_BITS-1:0]  height_eff;
   logic [CFG8_BITS-1:0]  step_eff;

   logic                  hit_start;
   logic [CoordBits-1:0]  hit_x;
   logic [CoordBits-1:0]  hit_k;
   logic [PEN_Y_BITS-1:0] hit_y;
   logic [CoordBits-1:0]  hit_w;
   hit_status_type        hit_status;
   logic [CoordBits-1:0]  hit_xc;
   logic                  div_start;
   logic [CoordBits-1:0]  div_dividend;
   logic                  div_done;
   logic [CoordBits-1:0]  div_quot;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= CoordBits'(LINE_WIDTH_RST);
         line_height_ff   <= CFG8_BITS'(LINE_HEIGHT_RST);
         word_gap_ff      <= CFG8_BITS'(WORD_GAP_RST);
         step_size_ff     <= CFG8_BITS'(STEP_SIZE_RST);
         circle_x_ff      <= CoordBits'(CIRCLE_X_RST);
         circle_y_ff      <= CoordBits'(CIRCLE_Y_RST);
         circle_radius_ff <= (CoordBits - 1)'(CIRCLE_RADIUS_RST);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:    line_width_ff    <= csr_wdata;
            CSR_LINE_HEIGHT:   line_height_ff   <= csr_wdata[CFG8_BITS-1:0];
            CSR_WORD_GAP:      word_gap_ff      <= csr_wdata[CFG8_BITS-1:0];
            CSR_STEP_SIZE:     step_size_ff     <= csr_wdata[CFG8_BITS-1:0];
            CSR_CIRCLE_X:      circle_x_ff      <= csr_wdata;
            CSR_CIRCLE_Y:      circle_y_ff      <= csr_wdata;
            CSR_CIRCLE_RADIUS: circle_radius_ff <= csr_wdata[CoordBits-2:0];
            default: begin
            end
         endcase
      end
   end

   // zero height and zero step behave as one
   assign height_eff = (line_height_ff == '0) ? CFG8_BITS'(1) : line_height_ff;
   assign step_eff   = (step_size_ff == '0) ? CFG8_BITS'(1) : step_size_ff;

   // placement sequencer
   wwc_seq #(
      .CoordBits (CoordBits)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .line_width   (line_width_ff),
      .line_height  (height_eff),
      .word_gap     (word_gap_ff),
      .hit_start    (hit_start),
      .hit_x        (hit_x),
      .hit_k        (hit_k),
      .hit_y        (hit_y),
      .hit_w        (hit_w),
      .hit_status   (hit_status),
      .hit_xc       (hit_xc),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_done     (div_done),
      .div_quot     (div_quot)
   );

   // overlap test unit
   wwc_hit #(
      .CoordBits (CoordBits)
   ) u_hit (
      .clock  (clock),
      .reset  (reset),
      .start  (hit_start),
      .x_base (hit_x),
      .k      (hit_k),
      .y      (hit_y),
      .w      (hit_w),
      .h      (height_eff),
      .s      (step_eff),
      .cx     (circle_x_ff),
      .cy     (circle_y_ff),
      .r      (circle_radius_ff),
      .status (hit_status),
      .xc     (hit_xc)
   );

   // retry count divider
   wwc_div #(
      .CoordBits (CoordBits)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (step_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

/* design/wwc_div.sv */
// restoring divider, one quotient bit per cycle
// depends on wwc_pkg; divides the room left on a line by the step size
module wwc_div import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CoordBits-1:0] dividend,
   input  logic [CFG8_BITS-1:0] divisor,
   output logic                 done,
   output logic [CoordBits-1:0] quotient
);

   localparam int CntBits = $clog2(CoordBits + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic [CoordBits-1:0] quo_ff, quo_in;
   logic [CFG8_BITS-1:0] rem_ff, rem_in;
   logic [CFG8_BITS:0]   trial;
   logic                 fits;

   // one shift-and-subtract step
   assign trial = {rem_ff, quo_ff[CoordBits-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CntBits'(CoordBits);
         quo_in = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? CFG8_BITS'(trial - {1'b0, divisor}) : trial[CFG8_BITS-1:0];
         quo_in = {quo_ff[CoordBits-2:0], fits};
         cnt_in = cnt_ff - CntBits'(1);
         if (cnt_ff == CntBits'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/wwc_hit.sv */
// box against circle overlap test on one shared multiplier
// depends on wwc_pkg; also forms the candidate x as base plus k steps
module wwc_hit import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [CoordBits-1:0]  x_base,
   input  logic [CoordBits-1:0]  k,
   input  logic [PEN_Y_BITS-1:0] y,
   input  logic [CoordBits-1:0]  w,
   input  logic [CFG8_BITS-1:0]  h,
   input  logic [CFG8_BITS-1:0]  s,
   input  logic [CoordBits-1:0]  cx,
   input  logic [CoordBits-1:0]  cy,
   input  logic [CoordBits-2:0]  r,
   output hit_status_type        status,
   output logic [CoordBits-1:0]  xc
);

   // signed width of the doubled-scale distances
   localparam int DW      = ((CoordBits + 3) > 19) ? (CoordBits + 3) : 19;
   localparam int AccBits = 2 * CoordBits + 1;

   typedef enum logic [6:0] {
      H_IDLE = 7'b0000001,
      H_MUL  = 7'b0000010,
      H_DIFF = 7'b0000100,
      H_DIST = 7'b0001000,
      H_SQX  = 7'b0010000,
      H_SQY  = 7'b0100000,
      H_CMP  = 7'b1000000
   } hit_state_type;

   hit_state_type          state_ff, state_in;
   logic                   done_ff, done_in;
   logic                   hit_ff, hit_in;
   logic [CoordBits-1:0]   xb_ff, xb_in;
   logic [CoordBits-1:0]   k_ff, k_in;
   logic [CoordBits-1:0]   xc_ff, xc_in;
   logic [DW-1:0]          px_ff, px_in;
   logic [DW-1:0]          py_ff, py_in;
   logic [CoordBits-1:0]   mx_ff, mx_in;
   logic [CoordBits-1:0]   my_ff, my_in;
   logic [AccBits-1:0]     acc_ff, acc_in;

   logic [CoordBits-1:0]   mul_a, mul_b;
   logic [2*CoordBits-1:0] prod;
   logic [CoordBits-1:0]   r2;
   logic [DW-1:0]          ax, ay, dx, dy, r2_w;
   logic                   dx_neg, dy_neg, dx_pos, dy_pos;

   assign r2   = {r, 1'b0};
   assign r2_w = DW'(r2);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         H_MUL: begin
            mul_a = k_ff;
            mul_b = CoordBits'(s);
         end
         H_SQX: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
         end
         H_SQY: begin
            mul_a = my_ff;
            mul_b = my_ff;
         end
         H_CMP: begin
            mul_a = r2;
            mul_b = r2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = (2 * CoordBits)'(mul_a) * (2 * CoordBits)'(mul_b);

   // distance from the box edge to the centre, per axis
   assign ax     = px_ff[DW-1] ? (DW'(0) - px_ff) : px_ff;
   assign ay     = py_ff[DW-1] ? (DW'(0) - py_ff) : py_ff;
   assign dx     = ax - DW'(w);
   assign dy     = ay - DW'(h);
   assign dx_neg = dx[DW-1];
   assign dy_neg = dy[DW-1];
   assign dx_pos = !dx_neg && (dx != '0);
   assign dy_pos = !dy_neg && (dy != '0);

   // sequencing of one test
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;
      xb_in    = xb_ff;
      k_in     = k_ff;
      xc_in    = xc_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      acc_in   = acc_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               xb_in    = x_base;
               k_in     = k;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            xc_in    = CoordBits'(xb_ff + prod[CoordBits-1:0]);
            state_in = H_DIFF;
         end
         H_DIFF: begin
            px_in    = (DW'(cx) << 1) - (DW'(xc_ff) << 1) - DW'(w);
            py_in    = (DW'(cy) << 1) - (DW'(y) << 1) - DW'(h);
            state_in = H_DIST;
         end
         H_DIST: begin
            if (!dx_pos && !dy_pos) begin
               // centre inside the box span on both axes
               done_in  = 1'b1;
               hit_in   = (r != '0) || (dx_neg && dy_neg);
               state_in = H_IDLE;
            end else if ((dx_pos && (dx >= r2_w)) || (dy_pos && (dy >= r2_w))) begin
               // one axis alone already outside the radius
               done_in  = 1'b1;
               hit_in   = 1'b0;
               state_in = H_IDLE;
            end else begin
               mx_in    = dx_pos ? dx[CoordBits-1:0] : '0;
               my_in    = dy_pos ? dy[CoordBits-1:0] : '0;
               state_in = H_SQX;
            end
         end
         H_SQX: begin
            acc_in   = AccBits'(prod);
            state_in = H_SQY;
         end
         H_SQY: begin
            acc_in   = acc_ff + AccBits'(prod);
            state_in = H_CMP;
         end
         H_CMP: begin
            done_in  = 1'b1;
            hit_in   = acc_ff < AccBits'(prod);
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      xb_ff  <= xb_in;
      k_ff   <= k_in;
      xc_ff  <= xc_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      acc_ff <= acc_in;
   end

   assign status.done = done_ff;
   assign status.hit  = hit_ff;
   assign xc          = xc_ff;

endmodule

/* design/wwc_seq.sv */
// placement sequencer: pen state, line wrap, retry search, result register
// depends on wwc_pkg and the channel interfaces; drives wwc_hit and wwc_div
module wwc_seq import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   wwc_req_if.sink               req_ch,
   wwc_rsp_if.source             rsp_ch,
   input  logic [CoordBits-1:0]  line_width,
   input  logic [CFG8_BITS-1:0]  line_height,
   input  logic [CFG8_BITS-1:0]  word_gap,
   output logic                  hit_start,
   output logic [CoordBits-1:0]  hit_x,
   output logic [CoordBits-1:0]  hit_k,
   output logic [PEN_Y_BITS-1:0] hit_y,
   output logic [CoordBits-1:0]  hit_w,
   input  hit_status_type        hit_status,
   input  logic [CoordBits-1:0]  hit_xc,
   output logic                  div_start,
   output logic [CoordBits-1:0]  div_dividend,
   input  logic                  div_done,
   input  logic [CoordBits-1:0]  div_quot
);

   localparam int PenXBits = CoordBits + 2;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_T0   = 10'b0000000010,
      S_W0   = 10'b0000000100,
      S_DIV  = 10'b0000001000,
      S_TL   = 10'b0000010000,
      S_WL   = 10'b0000100000,
      S_BS   = 10'b0001000000,
      S_WB   = 10'b0010000000,
      S_NL   = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } seq_state_type;

   // line advance, saturating at the bottom of the y range
   function automatic logic [PEN_Y_BITS-1:0] next_line(input logic [PEN_Y_BITS-1:0] y,
                                                      input logic [CFG8_BITS-1:0] h);
      logic [PEN_Y_BITS:0] sum;
      sum = {1'b0, y} + (PEN_Y_BITS + 1)'(h);
      return sum[PEN_Y_BITS] ? {PEN_Y_BITS{1'b1}} : sum[PEN_Y_BITS-1:0];
   endfunction

   seq_state_type         state_ff, state_in;
   logic [PenXBits-1:0]   pen_x_ff, pen_x_in;
   logic [PEN_Y_BITS-1:0] pen_y_ff, pen_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CoordBits-1:0]  place_x_ff, place_x_in;
   logic [PEN_Y_BITS-1:0] place_y_ff, place_y_in;
   logic [CoordBits-1:0]  w_ff, w_in;
   logic [CoordBits-1:0]  x_ff, x_in;
   logic [PEN_Y_BITS-1:0] y_ff, y_in;
   logic [CoordBits-1:0]  last_ff, last_in;
   logic [CoordBits-1:0]  lo_ff, lo_in;
   logic [CoordBits-1:0]  hi_ff, hi_in;
   logic [CoordBits-1:0]  mid_ff, mid_in;
   logic [CoordBits-1:0]  xhi_ff, xhi_in;

   logic [PenXBits-1:0]   start_x;
   logic [PEN_Y_BITS-1:0] start_y;
   logic                  start_wrap;
   logic                  over;
   logic [CoordBits-1:0]  mid;
   logic                  load_rsp;

   // pen at the transfer, and whether the word fits on its line
   assign start_x    = req_ch.first_word ? '0 : pen_x_ff;
   assign start_y    = req_ch.first_word ? '0 : pen_y_ff;
   assign start_wrap = ((PenXBits + 1)'(start_x) + (PenXBits + 1)'(req_ch.word_width))
                       > (PenXBits + 1)'(line_width);

   // word passes the line from the current x
   assign over = ((CoordBits + 1)'(x_ff) + (CoordBits + 1)'(w_ff))
                 > (CoordBits + 1)'(line_width);

   assign mid          = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign div_dividend = line_width - w_ff - x_ff;

   assign hit_x = x_ff;
   assign hit_y = y_ff;
   assign hit_w = w_ff;

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      w_in         = w_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      xhi_in       = xhi_ff;
      hit_start    = 1'b0;
      hit_k        = '0;
      div_start    = 1'b0;
      load_rsp     = 1'b0;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               w_in     = req_ch.word_width;
               x_in     = start_wrap ? '0 : start_x[CoordBits-1:0];
               y_in     = start_wrap ? next_line(start_y, line_height) : start_y;
               state_in = S_T0;
            end
         end
         S_T0: begin
            hit_start = 1'b1;
            state_in  = S_W0;
         end
         S_W0: begin
            if (hit_status.done) begin
               if (!hit_status.hit) begin
                  state_in = S_OUT;
               end else if (over) begin
                  state_in = S_NL;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               last_in  = div_quot;
               state_in = (div_quot != '0) ? S_TL : S_NL;
            end
         end
         S_TL: begin
            hit_start = 1'b1;
            hit_k     = last_ff;
            state_in  = S_WL;
         end
         S_WL: begin
            if (hit_status.done) begin
               if (!hit_status.hit) begin
                  // last position on the line is clear: search the first clear one
                  lo_in    = CoordBits'(1);
                  hi_in    = last_ff;
                  xhi_in   = hit_xc;
                  state_in = S_BS;
               end else begin
                  state_in = S_NL;
               end
            end
         end
         S_BS: begin
            if (lo_ff < hi_ff) begin
               hit_start = 1'b1;
               hit_k     = mid;
               mid_in    = mid;
               state_in  = S_WB;
            end else begin
               x_in     = xhi_ff;
               state_in = S_OUT;
            end
         end
         S_WB: begin
            if (hit_status.done) begin
               if (hit_status.hit) begin
                  lo_in = mid_ff + CoordBits'(1);
               end else begin
                  hi_in  = mid_ff;
                  xhi_in = hit_xc;
               end
               state_in = S_BS;
            end
         end
         S_NL: begin
            x_in     = '0;
            y_in     = next_line(y_ff, line_height);
            state_in = S_T0;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               pen_x_in = PenXBits'(x_ff) + PenXBits'(w_ff) + PenXBits'(word_gap);
               pen_y_in = y_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      place_x_in   = place_x_ff;
      place_y_in   = place_y_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         place_x_in   = x_ff;
         place_y_in   = y_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and pen
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      place_x_ff <= place_x_in;
      place_y_ff <= place_y_in;
      w_ff       <= w_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      last_ff    <= last_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      xhi_ff     <= xhi_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.place_x = place_x_ff;
   assign rsp_ch.place_y = place_y_ff;

endmodule

/* design/wwc_checker.sv */
// port-level checks of the word wrap around circle unit, bound to the top level
// depends on wwc_pkg and assert_macros.svh
`include "assert_macros.svh"

module wwc_checker import wwc_pkg::*; #(
   parameter int CoordBits = COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CoordBits-1:0]  place_x,
   input logic [PEN_Y_BITS-1:0] place_y
);

   // stalled result holds
   `WWC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(place_x) && $stable(place_y), "result changed while stalled")

   // one item in flight: input closes after a transfer
   `WWC_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "input still open after a transfer")

   // a fresh result frees the input side
   `WWC_ASSERT_IMP(a_ready_with_rsp, clock, reset, $rose(rsp_valid), req_ready, "input not open when a result appears")

   // no result the cycle after a transfer
   `WWC_ASSERT_NXT(a_min_latency, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result too early after a transfer")

endmodule

bind word_wrap_around_circle_unit wwc_checker #(
   .CoordBits (CoordBits)
) u_wwc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .place_x   (rsp_ch.place_x),
   .place_y   (rsp_ch.place_y)
);
